FILE: design/mrbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbc_pkg
// Shared types and constants for the memory region bounds checker: table
// size, field widths, beat layouts, command and status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mrbc_pkg;

    localparam int REGION_SLOTS = 256;
    localparam int ADDR_BITS    = 64;

    localparam int IDX_W  = $clog2(REGION_SLOTS);
    localparam int CNT_W  = $clog2(REGION_SLOTS + 1);

    localparam int LEN_W    = 64;
    localparam int ID_W     = 32;
    localparam int ACTIVE_W = 9;
    localparam int BYTES_W  = 64;
    localparam int SUM_W    = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

    // input beat layout
    localparam int IN_ADDR_LSB   = 0;
    localparam int IN_LEN_LSB    = 64;
    localparam int IN_RO_BIT     = 128;
    localparam int IN_WR_BIT     = 129;
    localparam int IN_RID_LSB    = 130;
    localparam int IN_FIELDS_W   = 162;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W    = 2;

    // output beat layout
    localparam int OUT_FIELDS_W  = 3 + ID_W + 1 + ACTIVE_W + BYTES_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_CHECK      = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_ARG   = 3'd1,
        STS_FULL      = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_OUTSIDE   = 3'd4,
        STS_READ_ONLY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             write_protect;
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] size;
        logic [ADDR_BITS-1:0] base;
    } slot_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic finish;
        logic post;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pre_done;
        logic hit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: design/mrbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbc_ctrl
// Controller: takes one beat, steps the slot scan until the datapath reports
// a decision, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mrbc_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  mrbc_pkg::dp_status_t   stat,
    output mrbc_pkg::ctrl_cmd_t    cmd
);

    mrbc_pkg::state_t state_reg;
    mrbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrbc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            mrbc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mrbc_pkg::S_SCAN;
                end
            end
            mrbc_pkg::S_SCAN:
            begin
                if (stat.pre_done || stat.hit || stat.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = mrbc_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_en = 1'b1;
                end
            end
            mrbc_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = mrbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mrbc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/mrbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbc_dp
// Datapath: item registers, slot memory with registered read, valid bits,
// scan pointer, match logic, region and byte totals, output register.
// ----------------------------------------------------------------------------
module mrbc_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  [mrbc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire  [mrbc_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [mrbc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  mrbc_pkg::ctrl_cmd_t                  cmd,
    output mrbc_pkg::dp_status_t                 stat
);

    // item
    mrbc_pkg::cmd_t                       item_cmd_reg;
    logic [mrbc_pkg::ADDR_BITS-1:0]       item_addr_reg;
    logic [mrbc_pkg::LEN_W-1:0]           item_len_reg;
    logic                                 item_ro_reg;
    logic                                 item_wr_reg;
    logic [mrbc_pkg::ID_W-1:0]            item_rid_reg;
    logic [mrbc_pkg::SUM_W-1:0]           acc_end_reg;

    // slot table
    mrbc_pkg::slot_t                      slot_mem [mrbc_pkg::REGION_SLOTS];
    logic [mrbc_pkg::REGION_SLOTS-1:0]    valid_reg;

    // scan
    logic [mrbc_pkg::IDX_W-1:0]           scan_idx_reg;
    logic                                 rd_live_reg;
    logic [mrbc_pkg::IDX_W-1:0]           rd_idx_reg;
    logic                                 rd_valid_reg;
    mrbc_pkg::slot_t                      rd_slot_reg;

    // state totals
    logic [mrbc_pkg::ID_W-1:0]            next_id_reg;
    logic [mrbc_pkg::CNT_W-1:0]           total_reg;
    logic [mrbc_pkg::BYTES_W-1:0]         bytes_reg;

    // pending result and output
    mrbc_pkg::status_t                    res_status_reg;
    logic [mrbc_pkg::ID_W-1:0]            res_id_reg;
    logic                                 res_granted_reg;
    logic                                 out_valid_reg;
    mrbc_pkg::status_t                    out_status_reg;
    logic [mrbc_pkg::ID_W-1:0]            out_id_reg;
    logic                                 out_granted_reg;
    logic [mrbc_pkg::ACTIVE_W-1:0]        out_active_reg;
    logic [mrbc_pkg::BYTES_W-1:0]         out_bytes_reg;

    logic [mrbc_pkg::SUM_W-1:0]           reg_end;
    logic                                 in_region;
    logic                                 pre_done;
    logic                                 hit;
    mrbc_pkg::status_t                    fin_status;
    logic [mrbc_pkg::ID_W-1:0]            fin_id;
    logic                                 fin_granted;
    logic                                 do_alloc;
    logic                                 do_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg  <= mrbc_pkg::cmd_t'(s_tuser);
            item_addr_reg <= s_tdata[mrbc_pkg::IN_ADDR_LSB +: mrbc_pkg::ADDR_BITS];
            item_len_reg  <= s_tdata[mrbc_pkg::IN_LEN_LSB +: mrbc_pkg::LEN_W];
            item_ro_reg   <= s_tdata[mrbc_pkg::IN_RO_BIT];
            item_wr_reg   <= s_tdata[mrbc_pkg::IN_WR_BIT];
            item_rid_reg  <= s_tdata[mrbc_pkg::IN_RID_LSB +: mrbc_pkg::ID_W];
            acc_end_reg   <=
                mrbc_pkg::SUM_W'(s_tdata[mrbc_pkg::IN_ADDR_LSB +: mrbc_pkg::ADDR_BITS])
                + mrbc_pkg::SUM_W'(s_tdata[mrbc_pkg::IN_LEN_LSB +: mrbc_pkg::LEN_W]);
        end
    end

    // slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_alloc)
        begin
            slot_mem[rd_idx_reg] <= '{write_protect: item_ro_reg, id: next_id_reg,
                                      size: item_len_reg, base: item_addr_reg};
        end
        if (cmd.scan_en)
        begin
            rd_slot_reg  <= slot_mem[scan_idx_reg];
            rd_valid_reg <= valid_reg[scan_idx_reg];
            rd_idx_reg   <= scan_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_live_reg  <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.scan_en;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    assign reg_end = mrbc_pkg::SUM_W'(rd_slot_reg.base) + mrbc_pkg::SUM_W'(rd_slot_reg.size);
    assign in_region = (item_addr_reg >= rd_slot_reg.base) && (acc_end_reg <= reg_end);

    always_comb
    begin
        pre_done = 1'b1;
        hit      = 1'b0;
        unique case (item_cmd_reg)
            mrbc_pkg::CMD_REGISTER:
            begin
                pre_done = (item_addr_reg == '0) || (item_len_reg == '0);
                hit      = rd_live_reg && !rd_valid_reg;
            end
            mrbc_pkg::CMD_UNREGISTER:
            begin
                pre_done = (item_rid_reg == '0);
                hit      = rd_live_reg && rd_valid_reg && (rd_slot_reg.id == item_rid_reg);
            end
            mrbc_pkg::CMD_CHECK:
            begin
                pre_done = (item_addr_reg == '0) || (item_len_reg == '0);
                hit      = rd_live_reg && rd_valid_reg && in_region;
            end
            mrbc_pkg::CMD_NONE:
            begin
                pre_done = 1'b1;
                hit      = 1'b0;
            end
            default:
            begin
                pre_done = 1'b1;
                hit      = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fin_status  = mrbc_pkg::STS_BAD_ARG;
        fin_id      = '0;
        fin_granted = 1'b0;
        do_alloc    = 1'b0;
        do_free     = 1'b0;
        unique case (item_cmd_reg)
            mrbc_pkg::CMD_REGISTER:
            begin
                priority if (pre_done)
                begin
                    fin_status = mrbc_pkg::STS_BAD_ARG;
                end
                else if (hit)
                begin
                    fin_status  = mrbc_pkg::STS_OK;
                    fin_id      = next_id_reg;
                    fin_granted = 1'b1;
                    do_alloc    = 1'b1;
                end
                else
                begin
                    fin_status = mrbc_pkg::STS_FULL;
                end
            end
            mrbc_pkg::CMD_UNREGISTER:
            begin
                priority if (pre_done)
                begin
                    fin_status = mrbc_pkg::STS_BAD_ARG;
                end
                else if (hit)
                begin
                    fin_status  = mrbc_pkg::STS_OK;
                    fin_granted = 1'b1;
                    do_free     = 1'b1;
                end
                else
                begin
                    fin_status = mrbc_pkg::STS_NOT_FOUND;
                end
            end
            mrbc_pkg::CMD_CHECK:
            begin
                priority if (item_addr_reg == '0)
                begin
                    fin_status = mrbc_pkg::STS_BAD_ARG;
                end
                else if (item_len_reg == '0)
                begin
                    fin_status  = mrbc_pkg::STS_OK;
                    fin_granted = 1'b1;
                end
                else if (hit && item_wr_reg && rd_slot_reg.write_protect)
                begin
                    fin_status = mrbc_pkg::STS_READ_ONLY;
                end
                else if (hit)
                begin
                    fin_status  = mrbc_pkg::STS_OK;
                    fin_granted = 1'b1;
                end
                else
                begin
                    fin_status = mrbc_pkg::STS_OUTSIDE;
                end
            end
            mrbc_pkg::CMD_NONE:
            begin
                fin_status = mrbc_pkg::STS_BAD_ARG;
            end
            default:
            begin
                fin_status = mrbc_pkg::STS_BAD_ARG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            next_id_reg <= mrbc_pkg::ID_W'(1);
            total_reg   <= '0;
            bytes_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            if (do_alloc)
            begin
                valid_reg[rd_idx_reg] <= 1'b1;
                next_id_reg           <= next_id_reg + 1'b1;
                total_reg             <= total_reg + 1'b1;
                bytes_reg             <= bytes_reg + item_len_reg;
            end
            else if (do_free)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                total_reg             <= total_reg - 1'b1;
                bytes_reg             <= bytes_reg - rd_slot_reg.size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status_reg  <= fin_status;
            res_id_reg      <= fin_id;
            res_granted_reg <= fin_granted;
        end
        if (cmd.post)
        begin
            out_status_reg  <= res_status_reg;
            out_id_reg      <= res_id_reg;
            out_granted_reg <= res_granted_reg;
            out_active_reg  <= mrbc_pkg::ACTIVE_W'(total_reg);
            out_bytes_reg   <= bytes_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{mrbc_pkg::OUT_PAD_W{1'b0}}, out_bytes_reg, out_active_reg,
                       out_granted_reg, out_id_reg, out_status_reg};

    assign stat.pre_done = pre_done;
    assign stat.hit      = hit;
    assign stat.last     = rd_live_reg &&
                           (rd_idx_reg == mrbc_pkg::IDX_W'(mrbc_pkg::REGION_SLOTS - 1));
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

FILE: design/memory_region_bounds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the input beat is loaded in S_IDLE; S_SCAN ends at once when the arguments
//   decide alone, else it reads slots until a hit or the last slot; S_DONE posts the result.
// Throughput: one command at a time, one slot read per cycle; the next beat is taken
//   in the cycle after the result is posted.
// A result held by m_axis_tready stalls the next post. Reset: valid bits, totals
//   and next ID clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// memory_region_bounds_checker
// Table of protected regions: register, unregister by ID, check an access
// against the first valid region in slot order.
// ----------------------------------------------------------------------------
module memory_region_bounds_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // address[63:0], length[127:64], write_protect[128], is_write[129],
    // target_id[161:130], zero pad
    input  wire  [mrbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[1:0]
    input  wire  [mrbc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // status[2:0], new_id[34:3], granted[35], active_regions[44:36],
    // protected_bytes[108:45], zero pad
    output logic [mrbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    mrbc_pkg::ctrl_cmd_t  ctrl_cmd;
    mrbc_pkg::dp_status_t dp_stat;

    mrbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    mrbc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat)
    );

endmodule
`default_nettype wire

FILE: design/mrbc_sva.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrbc_sva
// Port-level checks for the region bounds checker, bound to the top level.
// ----------------------------------------------------------------------------
module mrbc_sva (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 s_axis_tvalid,
    input wire                                 s_axis_tready,
    input wire [mrbc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input wire [mrbc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [mrbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one command in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a command is in flight");

    // granted exactly when status is ok
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[35] == (m_axis_tdata[2:0] == mrbc_pkg::STS_OK)))
        else $error("granted disagrees with status");

    // a nonzero ID only with an ok status
    a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[34:3] != '0) |-> m_axis_tdata[2:0] == mrbc_pkg::STS_OK)
        else $error("new ID on a failed command");

endmodule

bind memory_region_bounds_checker mrbc_sva u_mrbc_sva (.*);
`default_nettype wire

FILE: test/mrbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbc_checker
// Watches both streams of the region bounds checker. It keeps its own copy of
// the region table, works out the response to every accepted command beat and
// compares each output beat, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module mrbc_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    // address, length, write_protect, is_write, target_id, zero pad
    input  wire  [mrbc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd
    input  wire  [mrbc_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    // status, new_id, granted, active_regions, protected_bytes, zero pad
    input  wire  [mrbc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                  mismatch_count,
    output int                                  awaiting
);
    import mrbc_pkg::*;

    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

    typedef struct packed {
        logic [BYTES_W-1:0]  bytes;
        logic [ACTIVE_W-1:0] active;
        logic                granted;
        logic [ID_W-1:0]     new_id;
        status_t             status;
    } response_t;

    logic [ADDR_BITS-1:0] tbl_base [REGION_SLOTS];
    logic [LEN_W-1:0]     tbl_size [REGION_SLOTS];
    logic                 tbl_ro   [REGION_SLOTS];
    logic [ID_W-1:0]      tbl_id   [REGION_SLOTS];
    logic                 tbl_live [REGION_SLOTS];
    logic [ID_W-1:0]      id_next;
    logic [CNT_W-1:0]     live_count;
    logic [BYTES_W-1:0]   byte_sum;

    response_t awaited_responses[$];
    int        mismatch_total = 0;

    function automatic response_t table_response(input cmd_t cmd, input logic [63:0] addr_in,
                                                 input logic [63:0] len, input logic ro,
                                                 input logic wr, input logic [31:0] rid);
        response_t   v;
        logic [63:0] a;
        logic        found;
        v = '0;
        v.status = STS_BAD_ARG;
        a = addr_in & ADDR_MASK;
        found = 1'b0;
        case (cmd)
            CMD_REGISTER:
                if (a != 0 && len != 0)
                begin
                    v.status = STS_FULL;
                    for (int i = 0; i < REGION_SLOTS; i++)
                    begin
                        if (!found && !tbl_live[i])
                        begin
                            found       = 1'b1;
                            tbl_base[i] = a;
                            tbl_size[i] = len;
                            tbl_ro[i]   = ro;
                            tbl_id[i]   = id_next;
                            tbl_live[i] = 1'b1;
                            v.new_id    = id_next;
                            v.status    = STS_OK;
                            v.granted   = 1'b1;
                            id_next     = id_next + 1'b1;
                            live_count  = live_count + 1'b1;
                            byte_sum    = byte_sum + len;
                        end
                    end
                end
            CMD_UNREGISTER:
                if (rid != 0)
                begin
                    v.status = STS_NOT_FOUND;
                    for (int i = 0; i < REGION_SLOTS; i++)
                    begin
                        if (!found && tbl_live[i] && tbl_id[i] == rid)
                        begin
                            found       = 1'b1;
                            tbl_live[i] = 1'b0;
                            byte_sum    = byte_sum - tbl_size[i];
                            live_count  = live_count - 1'b1;
                            v.status    = STS_OK;
                            v.granted   = 1'b1;
                        end
                    end
                end
            CMD_CHECK:
                if (a != 0 && len == 0)
                begin
                    v.status  = STS_OK;
                    v.granted = 1'b1;
                end
                else if (a != 0)
                begin
                    v.status = STS_OUTSIDE;
                    for (int i = 0; i < REGION_SLOTS; i++)
                    begin
                        // access end and region end compared at 65 bits
                        if (!found && tbl_live[i] && a >= tbl_base[i] &&
                            ({1'b0, a} + {1'b0, len}) <=
                            ({1'b0, tbl_base[i]} + {1'b0, tbl_size[i]}))
                        begin
                            found = 1'b1;
                            if (wr && tbl_ro[i])
                                v.status = STS_READ_ONLY;
                            else
                            begin
                                v.status  = STS_OK;
                                v.granted = 1'b1;
                            end
                        end
                    end
                end
            default: ;
        endcase
        v.active = live_count;
        v.bytes  = byte_sum;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        response_t got;
        response_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REGION_SLOTS; i++)
                tbl_live[i] = 1'b0;
            id_next    = ID_W'(1);
            live_count = '0;
            byte_sum   = '0;
            awaited_responses.delete();
            awaiting       <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = response_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (awaited_responses.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("checker: result beat with nothing awaited: %h", m_tdata);
                    mismatch_total++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (got.status !== want.status || got.new_id !== want.new_id ||
                        got.granted !== want.granted || got.active !== want.active ||
                        got.bytes !== want.bytes)
                    begin
                        if (mismatch_total < 10)
                            $display({"checker: mismatch want st=%0d id=%0d ok=%0d act=%0d ",
                                      "bytes=%h got st=%0d id=%0d ok=%0d act=%0d bytes=%h"},
                                     want.status, want.new_id, want.granted, want.active,
                                     want.bytes, got.status, got.new_id, got.granted,
                                     got.active, got.bytes);
                        mismatch_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_responses.push_back(table_response(
                    cmd_t'(s_tuser),
                    s_tdata[IN_ADDR_LSB +: ADDR_BITS],
                    s_tdata[IN_LEN_LSB +: LEN_W],
                    s_tdata[IN_RO_BIT],
                    s_tdata[IN_WR_BIT],
                    s_tdata[IN_RID_LSB +: ID_W]));
            awaiting       <= awaited_responses.size();
            mismatch_count <= mismatch_total;
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the memory region bounds checker: directed edge
// cases first, then random register, unregister, check and no-op traffic with one
// fill of the whole table and a drain, random gaps on both streams and one
// long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import mrbc_pkg::*;

    localparam int ITEMS          = 1100;
    localparam int FILL_START     = 250;
    localparam int HOLD_OFF       = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     size;
    } region_rec_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    wire                    s_axis_tready;
    // address, length, write_protect, is_write, target_id, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // cmd
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready;
    // status, new_id, granted, active_regions, protected_bytes, zero pad
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int awaiting;
    int idle_cycles = 0;
    int tx_quiet = 0;

    region_rec_t     live_regions[$];
    logic [ID_W-1:0] id_issue = ID_W'(1);

    always #10 clk = ~clk;

    memory_region_bounds_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mrbc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .mismatch_count (mismatches),
        .awaiting       (awaiting)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly a small window so that regions overlap
    function automatic logic [63:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return rand64();
            1:       return {48'hFFFF_FFFF_FFFF, 16'($urandom)};
            default: return 64'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [63:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return rand64();
            1:       return ~64'($urandom_range(0, 4095));
            default: return 64'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic send_command(input cmd_t cmd, input logic [63:0] addr,
                                input logic [63:0] len, input logic ro, input logic wr,
                                input logic [31:0] rid);
        logic [IN_TDATA_W-1:0] beat;
        int                    gap;
        int                    idx;
        beat = '0;
        beat[IN_FIELDS_W-1:0] = {rid, wr, ro, len, addr};
        if (tx_quiet > 0)
        begin
            gap = 0;
            tx_quiet--;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            gap = 0;
            tx_quiet = $urandom_range(10, 40);
        end
        else
            gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        // track live IDs so that later beats can aim at real regions
        if (cmd == CMD_REGISTER && addr != 0 && len != 0 &&
            live_regions.size() < REGION_SLOTS)
        begin
            live_regions.push_back('{id_issue, addr, len});
            id_issue++;
        end
        else if (cmd == CMD_UNREGISTER && rid != 0)
        begin
            idx = -1;
            foreach (live_regions[i])
                if (idx < 0 && live_regions[i].id == rid)
                    idx = i;
            if (idx >= 0)
                live_regions.delete(idx);
        end
    endtask

    // mode 0 mixed traffic, 1 filling the table, 2 draining it
    task automatic send_random(input int mode);
        int          roll;
        int          pick;
        cmd_t        cmd;
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] off;
        logic [31:0] rid;
        logic        ro;
        logic        wr;
        region_rec_t r;
        roll = $urandom_range(0, 99);
        if (mode == 1)
            cmd = (roll < 85) ? CMD_REGISTER : CMD_CHECK;
        else if (mode == 2)
        begin
            if (roll < 75)
                cmd = CMD_UNREGISTER;
            else if (roll < 95)
                cmd = CMD_CHECK;
            else
                cmd = CMD_REGISTER;
        end
        else
        begin
            if (roll < 30)
                cmd = CMD_REGISTER;
            else if (roll < 55)
                cmd = CMD_UNREGISTER;
            else if (roll < 95)
                cmd = CMD_CHECK;
            else
                cmd = CMD_NONE;
        end
        addr = rand64();
        len  = rand64();
        rid  = $urandom;
        ro   = 1'($urandom_range(0, 1));
        wr   = 1'($urandom_range(0, 1));
        case (cmd)
            CMD_REGISTER:
            begin
                addr = pick_base();
                len  = pick_len();
                if ($urandom_range(0, 31) == 0)
                    addr = '0;
                if ($urandom_range(0, 31) == 0)
                    len = '0;
            end
            CMD_UNREGISTER:
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14 && live_regions.size() > 0)
                    rid = live_regions[$urandom_range(0, live_regions.size() - 1)].id;
                else if (pick < 16)
                    rid = '0;
                else if (pick < 18)
                    rid = id_issue;
            end
            CMD_CHECK:
            begin
                pick = $urandom_range(0, 19);
                if (pick < 13 && live_regions.size() > 0)
                begin
                    r = live_regions[$urandom_range(0, live_regions.size() - 1)];
                    case (pick % 4)
                        0:
                        begin
                            off  = rand64() % r.size;
                            addr = r.base + off;
                            len  = 1 + rand64() % (r.size - off);
                        end
                        1:
                        begin
                            addr = r.base;
                            len  = r.size;
                        end
                        2:
                        begin
                            addr = r.base;
                            len  = r.size + 1;
                        end
                        default:
                        begin
                            addr = r.base + r.size - 1;
                            len  = 64'($urandom_range(1, 2));
                        end
                    endcase
                end
                else if (pick < 15)
                    addr = '0;
                else if (pick < 17)
                begin
                    addr = pick_base();
                    len  = '0;
                end
                else
                begin
                    addr = pick_base();
                    len  = pick_len();
                end
            end
            default: ;
        endcase
        send_command(cmd, addr, len, ro, wr, rid);
    endtask

    initial
    begin : stimulus
        int mode;
        int full_tries;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_REGISTER;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_CHECK, 64'h1000, 64'h10, 1'b0, 1'b0, 32'h0);
        send_command(CMD_CHECK, 64'h0, 64'h8, 1'b0, 1'b1, 32'h0);
        send_command(CMD_CHECK, 64'h5000, 64'h0, 1'b0, 1'b1, 32'h0);
        send_command(CMD_REGISTER, 64'h0, 64'h100, 1'b0, 1'b0, 32'h0);
        send_command(CMD_REGISTER, 64'h2000, 64'h0, 1'b1, 1'b0, 32'h0);
        send_command(CMD_REGISTER, 64'h1000, 64'h1000, 1'b0, 1'b0, 32'h0);
        send_command(CMD_REGISTER, 64'h1800, 64'h100, 1'b1, 1'b0, 32'h0);
        send_command(CMD_REGISTER, 64'h9000, 64'h100, 1'b1, 1'b0, 32'h0);
        // region end beyond 64 bits; byte total wraps
        send_command(CMD_REGISTER, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b0, 1'b0, '1);
        send_command(CMD_CHECK, 64'h1800, 64'h10, 1'b0, 1'b1, 32'h0);
        send_command(CMD_CHECK, 64'h9000, 64'h100, 1'b0, 1'b1, 32'h0);
        send_command(CMD_CHECK, 64'h9000, 64'h100, 1'b1, 1'b0, 32'h0);
        send_command(CMD_CHECK, 64'h9001, 64'h100, 1'b0, 1'b0, 32'h0);
        send_command(CMD_CHECK, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b0, 1'b1, 32'h0);
        send_command(CMD_CHECK, '1, '1, 1'b1, 1'b1, '1);
        send_command(CMD_UNREGISTER, '1, '1, 1'b1, 1'b1, 32'h0);
        send_command(CMD_UNREGISTER, 64'h0, 64'h0, 1'b0, 1'b0, '1);
        send_command(CMD_UNREGISTER, 64'h0, 64'h0, 1'b0, 1'b0, 32'h1);
        send_command(CMD_CHECK, 64'h1800, 64'h10, 1'b0, 1'b1, 32'h0);
        send_command(CMD_NONE, '1, '1, 1'b1, 1'b1, '1);
        send_command(CMD_UNREGISTER, 64'h0, 64'h0, 1'b0, 1'b0, 32'h1);
        send_command(CMD_REGISTER, '1, 64'h1, 1'b1, 1'b0, 32'h0);
        send_command(CMD_CHECK, '1, 64'h1, 1'b0, 1'b1, 32'h0);
        send_command(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFE, 64'h2, 1'b0, 1'b0, 32'h0);

        mode = 0;
        full_tries = 0;
        for (int n = 0; n < ITEMS; n++)
        begin
            if (n == FILL_START)
                mode = 1;
            if (mode == 1 && live_regions.size() == REGION_SLOTS)
            begin
                full_tries++;
                if (full_tries > 12)
                    mode = 2;
            end
            if (mode == 2 && live_regions.size() < 10)
                mode = 0;
            send_random(mode);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        wait (awaiting == 0);
        repeat (REGION_SLOTS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin : sink
        int stall;
        int quiet;
        int taken;
        quiet = 0;
        taken = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 60)
                stall = HOLD_OFF;
            else if (quiet > 0)
            begin
                stall = 0;
                quiet--;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall = 0;
                quiet = $urandom_range(10, 40);
            end
            else
                stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

FILE: files.f
design/mrbc_pkg.sv
design/mrbc_ctrl.sv
design/mrbc_dp.sv
design/memory_region_bounds_checker.sv
design/mrbc_sva.sv
test/mrbc_checker.sv
test/tb.sv
